// File: rtl/base64_decoder_macros.svh
// assertion helpers shared by the decoder modules
`ifndef BASE64_DECODER_MACROS_SVH
`define BASE64_DECODER_MACROS_SVH

// checked only while out of reset
`define B64D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/b64d_pkg.sv
package b64d_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [5:0] VAL_PLUS  = 6'd62;
    localparam logic [5:0] VAL_SLASH = 6'd63;

    // one decoded group handed from the front to the back
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  nbytes;
        logic        eos;
        logic        bad;
    } t_job;

    // returns {valid, six-bit value}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = '0;
        ok = 1'b1;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + OFS_LOWER;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c - CHAR_DIGIT_0 + OFS_DIGIT;
        end else if (c == CHAR_PLUS) begin
            v = {2'b00, VAL_PLUS};
        end else if (c == CHAR_SLASH) begin
            v = {2'b00, VAL_SLASH};
        end else if (c == CHAR_PAD) begin
            v = '0;
        end else begin
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

// File: rtl/b64d_front.sv
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_character,
    input  logic             i_is_last,
    output logic             o_push,
    output b64d_pkg::t_job   o_job
);
    import b64d_pkg::*;

    logic [17:0] r_group, n_group;
    logic [1:0]  r_count, n_count;
    logic        r_prev_pad, n_prev_pad;
    logic        r_err, n_err;

    logic [6:0]  w_sx;
    logic [23:0] w_acc;
    logic [23:0] w_full;
    logic        w_pad;
    logic        w_err;
    logic [1:0]  w_npad;
    logic [2:0]  w_k;
    logic [2:0]  w_net;
    logic [1:0]  w_nbytes;

    always_comb begin
        w_sx   = sextet_of(i_character);
        w_pad  = (i_character == CHAR_PAD);
        w_acc  = {r_group, w_sx[5:0]};
        w_k    = {1'b0, r_count} + 3'd1;
        w_err  = r_err | ~w_sx[6] | (i_is_last & (r_count == 2'd0));
        w_npad = {1'b0, w_pad} + {1'b0, r_prev_pad};
        w_net  = w_k - {1'b0, w_npad};

        case (r_count)
            2'd1:    w_full = {w_acc[11:0], 12'd0};
            2'd2:    w_full = {w_acc[17:0], 6'd0};
            default: w_full = w_acc;
        endcase

        case (w_net)
            3'd2:    w_nbytes = 2'd1;
            3'd3:    w_nbytes = 2'd2;
            3'd4:    w_nbytes = 2'd3;
            default: w_nbytes = 2'd0;
        endcase

        n_group    = r_group;
        n_count    = r_count;
        n_prev_pad = r_prev_pad;
        n_err      = r_err;
        o_push     = 1'b0;
        o_job      = '0;

        if (i_accept) begin
            if (!i_is_last) begin
                if (r_count == 2'd3) begin
                    o_push       = 1'b1;
                    o_job.data   = w_acc;
                    o_job.nbytes = 2'd3;
                    n_group      = '0;
                    n_count      = '0;
                end else begin
                    n_group = w_acc[17:0];
                    n_count = r_count + 2'd1;
                end
                n_prev_pad = w_pad;
                n_err      = w_err;
            end else begin
                o_push    = 1'b1;
                o_job.eos = 1'b1;
                if (w_err) begin
                    o_job.bad = 1'b1;
                end else begin
                    o_job.data   = w_full;
                    o_job.nbytes = w_nbytes;
                end
                n_group    = '0;
                n_count    = '0;
                n_prev_pad = 1'b0;
                n_err      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group    <= '0;
            r_count    <= '0;
            r_prev_pad <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_group    <= n_group;
            r_count    <= n_count;
            r_prev_pad <= n_prev_pad;
            r_err      <= n_err;
        end
    end

endmodule

// File: rtl/b64d_fifo.sv
`include "base64_decoder_macros.svh"

module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64d_pkg::t_job   i_job,
    input  logic             i_pop,
    output b64d_pkg::t_job   o_head,
    output logic             o_empty,
    output logic             o_full
);
    import b64d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `B64D_ASSERT(a_push_has_room, i_push |-> !o_full, "push into full queue")
    `B64D_ASSERT(a_pop_has_data, i_pop |-> !o_empty, "pop from empty queue")

endmodule

// File: rtl/b64d_back.sv
`include "base64_decoder_macros.svh"

module b64d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64d_pkg::t_job   i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_valid,
    output logic             o_end_of_string,
    output logic             o_bad_input
);
    import b64d_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_bvalid, n_bvalid;
    logic       r_eos, n_eos;
    logic       r_bad, n_bad;

    logic       w_load;
    logic       w_last;
    logic [1:0] w_last_idx;

    always_comb begin
        w_load     = !i_empty && (!r_valid || i_ready);
        w_last_idx = (i_head.nbytes == 2'd0) ? 2'd0 : i_head.nbytes - 2'd1;
        w_last     = (r_idx == w_last_idx);

        n_idx    = r_idx;
        n_valid  = r_valid & ~i_ready;
        n_byte   = r_byte;
        n_bvalid = r_bvalid;
        n_eos    = r_eos;
        n_bad    = r_bad;
        o_pop    = 1'b0;

        if (w_load) begin
            n_valid  = 1'b1;
            n_bvalid = (i_head.nbytes != 2'd0);
            n_eos    = i_head.eos & w_last;
            n_bad    = i_head.bad & w_last;
            if (i_head.nbytes == 2'd0) begin
                n_byte = '0;
            end else begin
                case (r_idx)
                    2'd0:    n_byte = i_head.data[23:16];
                    2'd1:    n_byte = i_head.data[15:8];
                    default: n_byte = i_head.data[7:0];
                endcase
            end
            if (w_last) begin
                o_pop = 1'b1;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_bvalid <= n_bvalid;
        r_eos    <= n_eos;
        r_bad    <= n_bad;
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_end_of_string = r_eos;
    assign o_bad_input     = r_bad;

    `B64D_ASSERT(a_empty_word_zero, (o_valid && !o_byte_valid) |-> (o_data_byte == 8'd0),
        "word without byte carries nonzero data")
    `B64D_ASSERT(a_bad_is_final, (o_valid && o_bad_input) |-> (o_end_of_string && !o_byte_valid),
        "error flag outside final empty word")

endmodule

// File: rtl/base64_decoder.sv
// the last character of a group passes through the job queue and then the output register
// before its first result word appears on the output
// throughput: one character per cycle in, one word per cycle out while i_ready is high
// the front takes a character whenever the job queue has room; a group of four characters,
// or fewer at the end, forms one job of up to three words; the back drains one per cycle
// reset: synchronous active low, clears group state, queue pointers and output valid
module base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_character,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_string,
    output logic       o_bad_input
);
    import b64d_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_job w_job;
    t_job w_head;

    assign o_ready = !w_full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_valid & !w_full),
        .i_character (i_character),
        .i_is_last   (i_is_last),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_bad_input     (o_bad_input)
    );

endmodule
